@@ src/ltm_pkg.sv @@
// ltm_pkg: shared widths, sequencer states and flag struct of the loser-tree merge unit.
// No dependencies; imported by the interfaces, the compare unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ltm_pkg;

  localparam int unsigned KEY_W  = 32;  // record_key / out_key port width
  localparam int unsigned INFO_W = 32;  // record_info / out_info port width
  localparam int unsigned RUN_W  = 3;   // next_run port width
  localparam int unsigned CFG_W  = 4;   // active_runs register width

  localparam logic [CFG_W-1:0] ACTIVE_RUNS_RST = 4'd8;

  typedef enum logic [2:0] {
    ST_FILL,      // taking the first record of each run
    ST_BUILD_RD,  // leaf read issued for the build pass
    ST_BUILD_LD,  // leaf data back, start climbing
    ST_WALK,      // one tree level per cycle
    ST_OUT,       // winner to output register
    ST_MERGE      // waiting for the next record of the winning run
  } ltm_state_e;

  // Status of one contender in a match
  typedef struct packed {
    logic virt;  // virtual leaf, beats everything
    logic exh;   // run exhausted, loses to any real record
  } ltm_flag_t;

endpackage

`default_nettype wire

@@ src/ltm_cfg_if.sv @@
// ltm_cfg_if: configuration write channel carrying active_runs.
// Depends on ltm_pkg for the register width.
`timescale 1ns / 1ps
`default_nettype none

interface ltm_cfg_if
  import ltm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] active_runs;

  modport source (output valid, output active_runs, input ready);
  modport sink   (input valid, input active_runs, output ready);
endinterface

`default_nettype wire

@@ src/ltm_rec_if.sv @@
// ltm_rec_if: input record channel (key, info, empty-run flag).
// Depends on ltm_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ltm_rec_if
  import ltm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [KEY_W-1:0]  record_key;
  logic        [INFO_W-1:0] record_info;
  logic                     run_empty;

  modport source (output valid, output record_key, output record_info, output run_empty,
                  input ready);
  modport sink   (input valid, input record_key, input record_info, input run_empty,
                  output ready);
endinterface

`default_nettype wire

@@ src/ltm_res_if.sv @@
// ltm_res_if: result channel (winning record, its run, done flag).
// Depends on ltm_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ltm_res_if
  import ltm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [KEY_W-1:0]  out_key;
  logic        [INFO_W-1:0] out_info;
  logic        [RUN_W-1:0]  next_run;
  logic                     merge_done;

  modport source (output valid, output out_key, output out_info, output next_run,
                  output merge_done, input ready);
  modport sink   (input valid, input out_key, input out_info, input next_run,
                  input merge_done, output ready);
endinterface

`default_nettype wire

@@ src/ltm_cmp.sv @@
// ltm_cmp: the shared match unit of the loser tree; says whether contender a loses to b.
// Depends on ltm_pkg for ltm_flag_t.
`timescale 1ns / 1ps
`default_nettype none

module ltm_cmp
  import ltm_pkg::*;
#(
  parameter int KEY_BITS = 32
) (
  input  ltm_flag_t           a_flag_i,
  input  logic [KEY_BITS-1:0] a_key_i,
  input  ltm_flag_t           b_flag_i,
  input  logic [KEY_BITS-1:0] b_key_i,
  output logic                a_loses_o
);

  // between two live records a loses only when strictly greater; exhausted ties keep a in place
  always_comb begin
    if (a_flag_i.virt) begin
      a_loses_o = 1'b0;
    end else if (b_flag_i.virt) begin
      a_loses_o = 1'b1;
    end else if (a_flag_i.exh) begin
      a_loses_o = ~b_flag_i.exh;
    end else if (b_flag_i.exh) begin
      a_loses_o = 1'b0;
    end else begin
      a_loses_o = $signed(a_key_i) > $signed(b_key_i);
    end
  end

endmodule

`default_nettype wire

@@ src/loser_tree_kway_merge_unit.sv @@
// Loser-tree k-way merge unit: top level with sequencer, leaf and node memories.
// Depends on ltm_pkg, ltm_cfg_if, ltm_rec_if, ltm_res_if and ltm_cmp.
// Fill: one request per cycle, k records. Build: per leaf a leaf read, a load, then a climb
//   over the L levels on its path. Merge: each request is accepted, climbs one node per cycle,
//   then loads the output; L = floor(log2((run + k) / 2)) + 1. Node reads are the limit.
// Reset (rst_ni low, async): fill phase, fill count 0, active_runs = 8, output empty.
`timescale 1ns / 1ps
`default_nettype none

module loser_tree_kway_merge_unit
  import ltm_pkg::*;
#(
  parameter int MAX_RUNS = 8,
  parameter int KEY_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ltm_cfg_if.sink     cfg_i,
  ltm_rec_if.sink     rec_i,
  ltm_res_if.source   res_o
);

  // LW addresses a leaf or node; RW also holds k itself (the virtual leaf)
  localparam int LW     = $clog2(MAX_RUNS);
  localparam int RW     = $clog2(MAX_RUNS + 1);
  localparam int LEAF_W = 1 + KEY_BITS + INFO_W;
  localparam int NODE_W = RW + KEY_BITS + INFO_W + 1;

  // ---------------------------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------------------------
  ltm_state_e state_q, state_d;

  logic [CFG_W-1:0]    ar_q, ar_d;      // active_runs register
  logic [RW-1:0]       fill_q, fill_d;  // records taken in fill
  logic [RW-1:0]       idx_q, idx_d;    // leaf being inserted in the build pass
  logic                bld_q, bld_d;    // build pass in progress
  logic [LW-1:0]       t_q, t_d;        // node under match
  logic [MAX_RUNS-1:0] nvld_q, nvld_d;  // node written since build start

  // climbing contender
  logic [RW-1:0]       cand_run_q, cand_run_d;
  logic [KEY_BITS-1:0] cand_key_q, cand_key_d;
  logic [INFO_W-1:0]   cand_info_q, cand_info_d;
  logic                cand_exh_q, cand_exh_d;

  // overall winner (node 0)
  logic [RW-1:0]       win_run_q, win_run_d;
  logic [KEY_BITS-1:0] win_key_q, win_key_d;
  logic [INFO_W-1:0]   win_info_q, win_info_d;
  logic                win_exh_q, win_exh_d;

  // output register
  logic                    out_vld_q, out_vld_d;
  logic signed [KEY_W-1:0] out_key_q, out_key_d;
  logic [INFO_W-1:0]       out_info_q, out_info_d;
  logic [RUN_W-1:0]        out_run_q, out_run_d;
  logic                    out_done_q, out_done_d;

  // memories
  logic [LEAF_W-1:0] leaf_mem [MAX_RUNS];
  logic [LEAF_W-1:0] leaf_rd_q;
  logic [NODE_W-1:0] node_mem [MAX_RUNS];
  logic [NODE_W-1:0] node_rd_q;
  logic              node_rv_q;  // valid bit of the entry read

  logic          leaf_we, leaf_re;
  logic          node_we, node_re;
  logic [LW-1:0] node_ra;

  // ---------------------------------------------------------------------------------------------
  // Handshakes and derived values
  // ---------------------------------------------------------------------------------------------
  logic cfg_acc, in_acc, out_load, fin;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid & cfg_i.ready;
  assign rec_i.ready = (state_q == ST_FILL) || (state_q == ST_MERGE);
  assign in_acc      = rec_i.valid & rec_i.ready;

  // run count, clamped to 1..MAX_RUNS
  logic [RW-1:0] k_w;
  always_comb begin
    if (32'(ar_q) > 32'(MAX_RUNS)) begin
      k_w = RW'(MAX_RUNS);
    end else if (ar_q == '0) begin
      k_w = RW'(1);
    end else begin
      k_w = RW'(ar_q);
    end
  end

  logic [RW:0]   fill_inc;
  logic          fill_last;
  logic [RW:0]   sum_b, sum_m;
  logic [LW-1:0] t_build, t_merge, t_half;

  assign fill_inc  = {1'b0, fill_q} + (RW+1)'(1);
  assign fill_last = fill_inc >= {1'b0, k_w};
  assign sum_b     = {1'b0, idx_q} + {1'b0, k_w};
  assign sum_m     = {1'b0, win_run_q} + {1'b0, k_w};
  assign t_build   = sum_b[LW:1];  // first node above the leaf
  assign t_merge   = sum_m[LW:1];
  assign t_half    = t_q >> 1;

  // input record at key width
  logic [KEY_BITS-1:0] in_key;
  assign in_key = KEY_BITS'($unsigned(rec_i.record_key));

  // leaf read data
  logic                l_exh;
  logic [KEY_BITS-1:0] l_key;
  logic [INFO_W-1:0]   l_info;
  assign l_exh  = leaf_rd_q[LEAF_W-1];
  assign l_key  = leaf_rd_q[KEY_BITS+INFO_W-1 -: KEY_BITS];
  assign l_info = leaf_rd_q[INFO_W-1:0];

  // node read data; an unwritten node holds the virtual leaf
  logic [RW-1:0]       o_run, o_run_n;
  logic [KEY_BITS-1:0] o_key;
  logic [INFO_W-1:0]   o_info;
  logic                o_exh;
  ltm_flag_t           o_flag, c_flag;
  logic                c_loses;

  assign o_run   = node_rd_q[NODE_W-1 -: RW];
  assign o_key   = node_rd_q[INFO_W+KEY_BITS -: KEY_BITS];
  assign o_info  = node_rd_q[INFO_W:1];
  assign o_exh   = node_rd_q[0];
  assign o_flag  = '{virt: (~node_rv_q) | (o_run >= k_w), exh: o_exh};
  assign o_run_n = o_flag.virt ? k_w : o_run;
  assign c_flag  = '{virt: cand_run_q >= k_w, exh: cand_exh_q};

  ltm_cmp #(
    .KEY_BITS (KEY_BITS)
  ) u_cmp (
    .a_flag_i  (c_flag),
    .a_key_i   (cand_key_q),
    .b_flag_i  (o_flag),
    .b_key_i   (o_key),
    .a_loses_o (c_loses)
  );

  logic win_done;
  assign win_done = win_exh_q | (win_run_q >= k_w);
  assign out_load = (state_q == ST_OUT) && (~out_vld_q || res_o.ready) && ~cfg_acc;

  ltm_state_e walk_next;
  assign walk_next = (bld_q && (idx_q != '0)) ? ST_BUILD_RD : ST_OUT;

  // ---------------------------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_FILL: begin
        if (in_acc && fill_last) state_d = ST_BUILD_RD;
      end
      ST_MERGE: begin
        if (in_acc) state_d = (t_merge == '0) ? ST_OUT : ST_WALK;
      end
      ST_BUILD_RD: state_d = ST_BUILD_LD;
      ST_BUILD_LD: state_d = (t_build == '0) ? walk_next : ST_WALK;
      ST_WALK: begin
        if (t_half == '0) state_d = walk_next;
      end
      ST_OUT: begin
        if (out_load) state_d = win_done ? ST_FILL : ST_MERGE;
      end
      default: state_d = ST_FILL;
    endcase
    if (cfg_acc) state_d = ST_FILL;  // a write restarts the fill phase
  end

  // ---------------------------------------------------------------------------------------------
  // Sequencer: datapath controls
  // ---------------------------------------------------------------------------------------------
  always_comb begin
    ar_d        = ar_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    bld_d       = bld_q;
    t_d         = t_q;
    nvld_d      = nvld_q;
    cand_run_d  = cand_run_q;
    cand_key_d  = cand_key_q;
    cand_info_d = cand_info_q;
    cand_exh_d  = cand_exh_q;
    win_run_d   = win_run_q;
    win_key_d   = win_key_q;
    win_info_d  = win_info_q;
    win_exh_d   = win_exh_q;
    leaf_we     = 1'b0;
    leaf_re     = 1'b0;
    node_we     = 1'b0;
    node_re     = 1'b0;
    node_ra     = t_q;
    fin         = 1'b0;

    unique case (state_q)
      ST_FILL: begin
        if (in_acc) begin
          leaf_we = 1'b1;
          if (fill_last) begin
            fill_d = '0;
            idx_d  = k_w - RW'(1);
            bld_d  = 1'b1;
            nvld_d = '0;  // every node starts as the virtual leaf
          end else begin
            fill_d = fill_inc[RW-1:0];
          end
        end
      end
      ST_MERGE: begin
        if (in_acc) begin
          // the new record replaces the winner's leaf and climbs from there
          cand_run_d  = win_run_q;
          cand_key_d  = in_key;
          cand_info_d = rec_i.record_info;
          cand_exh_d  = rec_i.run_empty;
          t_d         = t_merge;
          node_ra     = t_merge;
          node_re     = t_merge != '0;
          fin         = t_merge == '0;
        end
      end
      ST_BUILD_RD: begin
        leaf_re = 1'b1;
      end
      ST_BUILD_LD: begin
        cand_run_d  = idx_q;
        cand_key_d  = l_key;
        cand_info_d = l_info;
        cand_exh_d  = l_exh;
        t_d         = t_build;
        node_ra     = t_build;
        node_re     = t_build != '0;
        fin         = t_build == '0;
      end
      ST_WALK: begin
        if (c_loses) begin
          // loser stays at this node, the node's occupant climbs on
          node_we            = 1'b1;
          nvld_d[32'(t_q)]   = 1'b1;
          cand_run_d         = o_run_n;
          cand_key_d         = o_key;
          cand_info_d        = o_info;
          cand_exh_d         = o_exh;
        end
        t_d     = t_half;
        node_ra = t_half;
        node_re = t_half != '0;
        fin     = t_half == '0;
      end
      ST_OUT: begin
        if (out_load && win_done) fill_d = '0;
      end
      default: begin
      end
    endcase

    if (fin) begin
      win_run_d  = cand_run_d;
      win_key_d  = cand_key_d;
      win_info_d = cand_info_d;
      win_exh_d  = cand_exh_d;
      if (bld_q && (idx_q != '0)) begin
        idx_d = idx_q - RW'(1);
      end else begin
        bld_d = 1'b0;
      end
    end

    if (cfg_acc) begin
      ar_d   = cfg_i.active_runs;
      fill_d = '0;
      bld_d  = 1'b0;
    end
  end

  // output register: a done result carries zero fields
  always_comb begin
    out_vld_d  = out_vld_q & ~res_o.ready;
    out_key_d  = out_key_q;
    out_info_d = out_info_q;
    out_run_d  = out_run_q;
    out_done_d = out_done_q;
    if (out_load) begin
      out_vld_d  = 1'b1;
      out_done_d = win_done;
      out_key_d  = win_done ? '0 : KEY_W'(win_key_q);
      out_info_d = win_done ? '0 : win_info_q;
      out_run_d  = win_done ? '0 : RUN_W'(win_run_q);
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_FILL;
      ar_q      <= ACTIVE_RUNS_RST;
      fill_q    <= '0;
      idx_q     <= '0;
      bld_q     <= 1'b0;
      t_q       <= '0;
      nvld_q    <= '0;
      node_rv_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ar_q      <= ar_d;
      fill_q    <= fill_d;
      idx_q     <= idx_d;
      bld_q     <= bld_d;
      t_q       <= t_d;
      nvld_q    <= nvld_d;
      out_vld_q <= out_vld_d;
      if (node_re) node_rv_q <= nvld_q[32'(node_ra)];
    end
  end

  always_ff @(posedge clk_i) begin
    cand_run_q  <= cand_run_d;
    cand_key_q  <= cand_key_d;
    cand_info_q <= cand_info_d;
    cand_exh_q  <= cand_exh_d;
    win_run_q   <= win_run_d;
    win_key_q   <= win_key_d;
    win_info_q  <= win_info_d;
    win_exh_q   <= win_exh_d;
    out_key_q   <= out_key_d;
    out_info_q  <= out_info_d;
    out_run_q   <= out_run_d;
    out_done_q  <= out_done_d;
  end

  // leaf memory: written in fill, read once per leaf in the build pass
  always_ff @(posedge clk_i) begin
    if (leaf_we) begin
      if (rec_i.run_empty) begin
        leaf_mem[fill_q[LW-1:0]] <= {1'b1, {KEY_BITS{1'b0}}, {INFO_W{1'b0}}};
      end else begin
        leaf_mem[fill_q[LW-1:0]] <= {1'b0, in_key, rec_i.record_info};
      end
    end
    if (leaf_re) leaf_rd_q <= leaf_mem[idx_q[LW-1:0]];
  end

  // loser node memory: holds a copy of each loser record so a match needs one read
  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[t_q] <= {cand_run_q, cand_key_q, cand_info_q, cand_exh_q};
    if (node_re) node_rd_q <= node_mem[node_ra];
  end

  // ---------------------------------------------------------------------------------------------
  // Result port
  // ---------------------------------------------------------------------------------------------
  assign res_o.valid      = out_vld_q;
  assign res_o.out_key    = out_key_q;
  assign res_o.out_info   = out_info_q;
  assign res_o.next_run   = out_run_q;
  assign res_o.merge_done = out_done_q;

endmodule

`default_nettype wire

@@ src/ltm_checker.sv @@
// ltm_checker: port-level assertions for the loser-tree merge unit, bound to the top level.
// Depends on ltm_rec_if and ltm_res_if.
`timescale 1ns / 1ps
`default_nettype none

module ltm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  ltm_rec_if.sink    rec_i,
  ltm_res_if.source  res_o
);

  // a stalled result stays up
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> res_o.valid)
    else $error("result dropped while stalled");

  // and keeps its fields
  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> $stable(res_o.out_key) && $stable(res_o.out_info)
      && $stable(res_o.next_run) && $stable(res_o.merge_done))
    else $error("result changed while stalled");

  // no result can appear in the cycle straight after a request
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_i.valid && rec_i.ready |=> !$rose(res_o.valid))
    else $error("result raised one cycle after a request");

  // a fresh result leaves the unit waiting for the next request
  a_ready_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> rec_i.ready)
    else $error("input not ready when a result appears");

endmodule

bind loser_tree_kway_merge_unit ltm_checker u_ltm_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .rec_i  (rec_i),
  .res_o  (res_o)
);

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking bench for loser_tree_kway_merge_unit. A behavioural loser tree
// predicts each winner and done result. Needs ltm_pkg, the three channel interfaces and the unit.

module tb_top;
  import ltm_pkg::*;

  localparam int RUNS_MAX      = 8;   // MAX_RUNS of the unit, default build
  localparam int RUN_DEPTH     = 12;  // longest sorted run built by the bench
  localparam int SETTLE_CYCLES = 64;  // longer than the build pass for eight leaves
  localparam int RANDOM_ITEMS  = 1350;

  // One result request as the unit gives it
  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic        [INFO_W-1:0] info;
    logic        [RUN_W-1:0]  run;
    logic                     done;
  } winner_t;

  logic clk_i;
  logic rst_ni;

  ltm_cfg_if cfg_if ();
  ltm_rec_if rec_if ();
  ltm_res_if res_if ();

  loser_tree_kway_merge_unit DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .rec_i (rec_if),
    .res_o (res_if)
  );

  // ---------------------------------------------------------------------------
  // Tree mirror: leaves, loser nodes (node 0 = winner), fill count, phase flag
  // ---------------------------------------------------------------------------
  logic        [CFG_W-1:0]  runs_reg;
  logic signed [KEY_W-1:0]  lf_key  [RUNS_MAX];
  logic        [INFO_W-1:0] lf_info [RUNS_MAX];
  bit                       lf_exh  [RUNS_MAX];
  logic        [3:0]        node_q  [RUNS_MAX];
  int                       fill_cnt;
  bit                       in_merge;

  winner_t winners_due [$];  // results owed by the unit, oldest first
  int      errors;
  int      records_sent;
  bit      calm;             // set: neither side idles

  // Sorted runs for well-formed merges
  int               run_key  [RUNS_MAX][RUN_DEPTH];
  logic [INFO_W-1:0] run_info [RUNS_MAX][RUN_DEPTH];
  int               run_len  [RUNS_MAX];
  int               run_pos  [RUNS_MAX];

  // 0 behaves as 1, anything above the leaf count as the leaf count
  function automatic int live_runs();
    if (runs_reg == 0) return 1;
    if (runs_reg > RUNS_MAX) return RUNS_MAX;
    return int'(runs_reg);
  endfunction

  // Run whose next record the unit asks for in the merge phase
  function automatic int wanted_run();
    int w;
    w = int'(node_q[0]);
    if (w >= live_runs()) w = 0;
    return w;
  endfunction

  // Leaf a loses to leaf b: strictly greater. Index >= k is the virtual leaf, never loses.
  function automatic bit outranked(int a, int b, int k);
    if (a >= k) return 1'b0;
    if (b >= k) return 1'b1;
    if (lf_exh[a]) return !lf_exh[b];
    if (lf_exh[b]) return 1'b0;
    return lf_key[a] > lf_key[b];
  endfunction

  // Replay matches from leaf s to the root, losers stay in the nodes
  function automatic void climb_from(int s, int k);
    int t;
    int other;
    t = (s + k) / 2;
    while (t > 0 && t < RUNS_MAX) begin
      other = int'(node_q[t]);
      if (outranked(s, other, k)) begin
        node_q[t] = s[3:0];
        s = other;
      end
      t = t / 2;
    end
    node_q[0] = s[3:0];
  endfunction

  function automatic void place_leaf(int i, logic signed [KEY_W-1:0] key,
                                     logic [INFO_W-1:0] info, logic empty);
    if (i >= RUNS_MAX) return;
    lf_exh[i]  = empty;
    lf_key[i]  = empty ? '0 : key;
    lf_info[i] = empty ? '0 : info;
  endfunction

  // Takes one accepted record request; queues the result it causes, if any
  function automatic void tree_take_record(logic signed [KEY_W-1:0] key,
                                           logic [INFO_W-1:0] info, logic empty);
    int      k;
    int      i;
    int      w;
    winner_t res;
    k = live_runs();
    if (!in_merge) begin
      if (fill_cnt >= k) fill_cnt = 0;
      place_leaf(fill_cnt, key, info, empty);
      fill_cnt++;
      if (fill_cnt < k) return;
      // build: every node starts with the virtual leaf, then each real leaf climbs
      for (i = 1; i < k; i++) node_q[i] = k[3:0];
      for (i = k; i > 0; i--) climb_from(i - 1, k);
      in_merge = 1'b1;
      fill_cnt = 0;
    end else begin
      i = int'(node_q[0]);
      if (i >= k) i = 0;
      place_leaf(i, key, info, empty);
      climb_from(i, k);
    end
    w = int'(node_q[0]);
    if (w >= k || w >= RUNS_MAX || lf_exh[w]) begin
      // all runs dry: done, back to fill
      res      = '0;
      res.done = 1'b1;
      in_merge = 1'b0;
      fill_cnt = 0;
    end else begin
      res.key  = lf_key[w];
      res.info = lf_info[w];
      res.run  = w[RUN_W-1:0];
      res.done = 1'b0;
    end
    winners_due.push_back(res);
  endfunction

  // Keys: mostly full range, some extremes, some from a tiny range to force ties
  function automatic int pick_key();
    case ($urandom_range(0, 7))
      0:       return int'($urandom_range(0, 6)) - 3;
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, result sink
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready <= calm || ($urandom_range(0, 99) >= 7);
    end
  end

  // Every accepted result against the oldest owed one
  always @(posedge clk_i) begin : check_results
    winner_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (winners_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("tb_top: unexpected result key %0d info %h run %0d done %b",
                   res_if.out_key, res_if.out_info, res_if.next_run, res_if.merge_done);
      end else begin
        want = winners_due.pop_front();
        if (res_if.out_key !== want.key || res_if.out_info !== want.info ||
            res_if.next_run !== want.run || res_if.merge_done !== want.done) begin
          errors++;
          if (errors <= 10)
            $display({"tb_top: mismatch exp key %0d info %h run %0d done %b, ",
                      "got key %0d info %h run %0d done %b"},
                     want.key, want.info, want.run, want.done,
                     res_if.out_key, res_if.out_info, res_if.next_run, res_if.merge_done);
        end
      end
    end
  end

  // Fail-safe against a hung handshake
  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driving tasks, all entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // One record request; valid stays high for a following request
  task automatic send_record(input logic signed [KEY_W-1:0] key,
                             input logic [INFO_W-1:0] info, input logic empty);
    if (!calm && $urandom_range(0, 99) < 7) begin
      rec_if.valid <= 1'b0;
      @(negedge clk_i);
      while (!calm && $urandom_range(0, 99) < 7) @(negedge clk_i);
    end
    rec_if.valid       <= 1'b1;
    rec_if.record_key  <= key;
    rec_if.record_info <= info;
    rec_if.run_empty   <= empty;
    @(posedge clk_i);
    while (!rec_if.ready) @(posedge clk_i);
    records_sent++;
    tree_take_record(key, info, empty);
    @(negedge clk_i);
  endtask

  // Stop sending, collect every owed result, then let any build pass finish
  task automatic settle_block();
    rec_if.valid <= 1'b0;
    while (winners_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Register write only on an idle unit; it also restarts the fill phase
  task automatic write_runs(input logic [CFG_W-1:0] value);
    settle_block();
    cfg_if.valid       <= 1'b1;
    cfg_if.active_runs <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    runs_reg = value;
    fill_cnt = 0;
    in_merge = 1'b0;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Builds k sorted runs and feeds them as the unit asks; stop_after < 0 runs to done
  task automatic merge_sorted_runs(input int stop_after);
    int              k;
    int              r;
    int              i;
    int              j;
    int              n;
    int              w;
    int              tmp;
    logic [INFO_W-1:0] ti;
    if (in_merge || fill_cnt != 0) write_runs(runs_reg);
    k = live_runs();
    for (r = 0; r < k; r++) begin
      if ($urandom_range(0, 9) == 0) run_len[r] = 0;
      else run_len[r] = $urandom_range(1, ($urandom_range(0, 7) == 0) ? RUN_DEPTH : 4);
      for (j = 0; j < run_len[r]; j++) begin
        tmp = pick_key();
        ti  = $urandom;
        i   = j - 1;
        while (i >= 0 && run_key[r][i] > tmp) begin
          run_key[r][i+1]  = run_key[r][i];
          run_info[r][i+1] = run_info[r][i];
          i--;
        end
        run_key[r][i+1]  = tmp;
        run_info[r][i+1] = ti;
      end
      run_pos[r] = 0;
    end
    n = 0;
    // fill: head of each run in run order, empty marker for a run with nothing in it
    for (r = 0; r < k; r++) begin
      if (run_len[r] > 0) begin
        send_record(run_key[r][0], run_info[r][0], 1'b0);
        run_pos[r] = 1;
      end else begin
        send_record(pick_key(), $urandom, 1'b1);
      end
      n++;
    end
    while (in_merge && (stop_after < 0 || n < stop_after)) begin
      w = wanted_run();
      if (run_pos[w] < run_len[w]) begin
        send_record(run_key[w][run_pos[w]], run_info[w][run_pos[w]], 1'b0);
        run_pos[w]++;
      end else begin
        send_record(pick_key(), $urandom, 1'b1);
      end
      n++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset run count of eight: key and payload extremes, a tie, a run empty from the start
  task automatic test_extreme_keys();
    send_record(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_record(32'sh8000_0000, 32'h0000_0000, 1'b0);
    send_record(0, 32'h5555_5555, 1'b0);
    send_record(-1, 32'hAAAA_AAAA, 1'b0);
    send_record(32'sh1234_5678, 32'hDEAD_BEEF, 1'b1);  // key and payload must be dropped
    send_record(5, 32'h0000_0001, 1'b0);
    send_record(5, 32'h0000_0002, 1'b0);                // equal key, lower run stays ahead
    send_record(32'sh7FFF_FFFF, 32'h0000_0003, 1'b0);   // ties with run 0 at the top
    // each request now drains the named run, ending in done
    while (in_merge) send_record(pick_key(), $urandom, 1'b1);
  endtask

  // Single run, a zero count that acts as one, and a restart in the middle of a merge
  task automatic test_short_runs();
    write_runs(4'd1);
    send_record(-7, 32'h0000_0077, 1'b0);
    send_record(0, 32'h0, 1'b1);
    write_runs(4'd0);
    send_record(0, 32'h0, 1'b1);                        // done straight out of fill
    send_record(42, 32'h0000_0009, 1'b0);
    send_record(0, 32'h0, 1'b1);
    write_runs(4'd2);
    send_record(100, 32'h0000_0100, 1'b0);
    send_record(-100, 32'h0000_0200, 1'b0);
    write_runs(4'd2);                                   // abandons the merge, back to fill
    send_record(3, 32'h0000_0300, 1'b0);
    send_record(3, 32'h0000_0400, 1'b1);
  endtask

  // Mostly complete merges of sorted runs, some cut short, some unordered noise
  task automatic test_random_merges();
    int start;
    int seq;
    int plan;
    int roll;
    int j;
    start = records_sent;
    seq   = 0;
    plan  = 0;
    while (records_sent - start < RANDOM_ITEMS) begin
      calm = (records_sent - start >= 500) && (records_sent - start < 850);
      if (seq % 5 == 0) begin
        case (plan)
          0:       write_runs(4'd15);
          1:       write_runs(4'd8);
          2:       write_runs(4'd1);
          default: write_runs(CFG_W'($urandom_range(0, 15)));
        endcase
        plan++;
      end
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        merge_sorted_runs(-1);
      end else if (roll < 90) begin
        merge_sorted_runs($urandom_range(1, 6));
      end else begin
        for (j = $urandom_range(1, 20); j > 0; j--)
          send_record(pick_key(), $urandom, $urandom_range(0, 3) == 0);
      end
      seq++;
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni             = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.active_runs = '0;
    rec_if.valid       = 1'b0;
    rec_if.record_key  = '0;
    rec_if.record_info = '0;
    rec_if.run_empty   = 1'b0;
    errors             = 0;
    records_sent       = 0;
    calm               = 1'b0;
    runs_reg           = ACTIVE_RUNS_RST;
    fill_cnt           = 0;
    in_merge           = 1'b0;
    for (int i = 0; i < RUNS_MAX; i++) begin
      lf_key[i]  = '0;
      lf_info[i] = '0;
      lf_exh[i]  = 1'b0;
      node_q[i]  = '0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_extreme_keys();
    test_short_runs();
    test_random_merges();

    settle_block();
    if (errors == 0 && winners_due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
